// File: rtl/ciir_pkg.sv
// Shared constants, types and state encodings for the cascaded IIR filter.
// No dependencies; imported by ciir_cfg, ciir_cell, cascaded_iir_filter_top and the testbench.
package ciir_pkg;

  // Filter geometry
  localparam int SECTIONS   = 8;
  localparam int ORDER      = 4;
  localparam int TAPS       = 2 * ORDER + 1;

  // Field widths
  localparam int SAMPLE_IN_W = 16;
  localparam int SAMPLE_W    = 24;
  localparam int COEF_W      = 18;
  localparam int LIMIT_W     = 23;
  localparam int IDX_W       = 7;
  localparam int SEC_FIELD_W = 3;
  localparam int SECC_W      = 4;
  localparam int ORDC_W      = 3;

  // Datapath widths
  localparam int PROD_W     = COEF_W + SAMPLE_W;
  localparam int ACC_W      = PROD_W + $clog2(TAPS);
  localparam int FRAC_SHIFT = 14;
  localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);
  localparam int YR_W       = ACC_W - FRAC_SHIFT;

  // Counter and index widths
  localparam int TAP_W  = $clog2(TAPS);
  localparam int XH_W   = $clog2(ORDER + 1);
  localparam int YH_W   = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int ORD_W  = $clog2(ORDER + 1);
  localparam int NSEC_W = $clog2(SECTIONS + 1);
  localparam int SIDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  // Register port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_SECTIONS = 2'd0;
  localparam logic [1:0] REG_ORDER    = 2'd1;
  localparam logic [1:0] REG_LIMIT    = 2'd2;

  // Input function codes
  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  typedef struct packed {
    logic [SECC_W-1:0]  sections;
    logic [ORDC_W-1:0]  order;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic                     we;
    logic [TAP_W-1:0]         tap;
    logic signed [COEF_W-1:0] value;
  } coef_wr_t;

  typedef struct packed {
    logic                       done;
    logic                       ovf;
    logic signed [SAMPLE_W-1:0] y;
  } cell_st_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_MAC,
    C_ROUND
  } cell_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_RUN,
    T_HOLD
  } top_state_t;

endpackage

// File: rtl/cascaded_iir_filter_top.sv
// Cascaded IIR filter top: register port, input/output channels, section chain.
// Depends on ciir_pkg, ciir_cfg and ciir_cell.
// The input transfer registers section 0's start; each section loads, walks its 2*K+1
// taps (K the saturated order) through its serial MAC and rounds, and its registered done
// starts the next. One sample at a time: the next is taken once the last result (or, with
// no sections, the sample) is loaded into the output register, so an output stall holds it.
// Coefficient writes only in idle. Synchronous reset clears histories, flags and registers.
module cascaded_iir_filter_top
  import ciir_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic signed [SAMPLE_IN_W-1:0] sample_in,
  input  logic                          last_of_block,
  input  logic [IDX_W-1:0]              coef_index,
  input  logic signed [COEF_W-1:0]      coef_value,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_W-1:0]    result_sample,
  output logic                          overflow,
  output logic [SEC_FIELD_W-1:0]        overflow_section
);

  cfg_t cfg;
  logic [NSEC_W-1:0] nsec, nsec_m1;
  logic [ORD_W-1:0]  ord;
  logic [SIDX_W-1:0] last_idx;

  top_state_t state, state_next;
  logic in_xfer, go, cap_run, cap_byp, cap_any, out_load;

  logic                       start0, last_q;
  logic signed [SAMPLE_W-1:0] x0;

  coef_wr_t                   cwr    [SECTIONS];
  cell_st_t                   cst    [SECTIONS];
  logic                       cstart [SECTIONS];
  logic signed [SAMPLE_W-1:0] cx     [SECTIONS];
  logic [SECTIONS-1:0]        done_vec;

  logic                   flag_any, err_set, err_active, rep_ovf, rep_last, fin_done;
  logic [SEC_FIELD_W-1:0] flag_idx, err_sec, rep_sec;
  logic                   res_ovf;
  logic [SEC_FIELD_W-1:0] res_sec;
  logic signed [SAMPLE_W-1:0] res_y;

  ciir_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // saturate the configured geometry
  assign nsec = ({1'b0, cfg.sections} > (SECC_W+1)'(SECTIONS)) ?
                NSEC_W'(SECTIONS) : NSEC_W'(cfg.sections);
  assign ord  = (cfg.order > ORDC_W'(ORDER)) ? ORD_W'(ORDER) : ORD_W'(cfg.order);
  assign nsec_m1  = nsec - NSEC_W'(1);
  assign last_idx = nsec_m1[SIDX_W-1:0];

  assign in_xfer = in_valid && !in_stall;

  // section chain
  for (genvar s = 0; s < SECTIONS; s++) begin : g_cell
    assign cwr[s].we = in_xfer && (func == FUNC_COEF) &&
                       ({1'b0, coef_index} >= (IDX_W+1)'(s * TAPS)) &&
                       ({1'b0, coef_index} <  (IDX_W+1)'((s + 1) * TAPS));
    assign cwr[s].tap   = TAP_W'(coef_index - IDX_W'(s * TAPS));
    assign cwr[s].value = coef_value;
    assign done_vec[s]  = cst[s].done;

    if (s == 0) begin : g_head
      assign cstart[s] = start0;
      assign cx[s]     = x0;
    end else begin : g_link
      assign cstart[s] = cst[s-1].done && (NSEC_W'(s) < nsec);
      assign cx[s]     = cst[s-1].y;
    end

    ciir_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .start (cstart[s]),
      .x_in  (cx[s]),
      .ord   (ord),
      .limit (cfg.limit),
      .cwr   (cwr[s]),
      .st    (cst[s])
    );
  end

  assign fin_done = done_vec[last_idx];

  // flagged section, highest index wins; at most one section finishes per cycle
  always_comb begin
    flag_any = 1'b0;
    flag_idx = '0;
    for (int i = 0; i < SECTIONS; i++) begin
      if (cst[i].done && cst[i].ovf) begin
        flag_any = 1'b1;
        flag_idx = SEC_FIELD_W'(i);
      end
    end
  end

  assign err_set  = flag_any && !err_active;
  assign rep_ovf  = err_active || err_set;
  assign rep_sec  = err_active ? err_sec : (err_set ? flag_idx : '0);
  assign rep_last = (state == T_IDLE) ? last_of_block : last_q;
  assign cap_any  = cap_run || cap_byp;

  // control
  always_ff @(posedge clk) begin
    if (rst) state <= T_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    go         = 1'b0;
    cap_run    = 1'b0;
    cap_byp    = 1'b0;
    out_load   = 1'b0;
    case (state)
      T_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && func == FUNC_FILTER) begin
          if (nsec == '0) begin
            cap_byp    = 1'b1;
            state_next = T_HOLD;
          end else begin
            go         = 1'b1;
            state_next = T_RUN;
          end
        end
      end
      T_RUN: begin
        if (fin_done) begin
          cap_run    = 1'b1;
          state_next = T_HOLD;
        end
      end
      T_HOLD: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  // sample entry
  always_ff @(posedge clk) begin
    if (rst) start0 <= 1'b0;
    else     start0 <= go;
    if (go) begin
      x0     <= SAMPLE_W'(sample_in);
      last_q <= last_of_block;
    end
  end

  // overflow flag, cleared after the block's last report
  always_ff @(posedge clk) begin
    if (rst) begin
      err_active <= 1'b0;
      err_sec    <= '0;
    end else if (cap_any && rep_last) begin
      err_active <= 1'b0;
      err_sec    <= '0;
    end else if (err_set) begin
      err_active <= 1'b1;
      err_sec    <= flag_idx;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (cap_any) begin
      res_y   <= cap_byp ? SAMPLE_W'(sample_in) : cst[last_idx].y;
      res_ovf <= rep_ovf;
      res_sec <= rep_sec;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (out_load) begin
      result_sample    <= res_y;
      overflow         <= res_ovf;
      overflow_section <= res_sec;
    end
  end

  // checks
  a_one_done: assert property (@(posedge clk) disable iff (rst)
    $onehot0(done_vec))
    else $error("more than one section finished in a cycle");

  a_done_run: assert property (@(posedge clk) disable iff (rst)
    (|done_vec) |-> (state == T_RUN))
    else $error("section finished outside a filter run");

  a_out_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == T_HOLD))
    else $error("result raised without a held result");

  a_sec_clear: assert property (@(posedge clk) disable iff (rst)
    !err_active |-> (err_sec == '0))
    else $error("overflow section set without overflow flag");

  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(err_active)) |-> $past(cap_any && rep_last))
    else $error("overflow flag cleared before end of block");

endmodule

// File: rtl/ciir_cfg.sv
// Configuration register block: section count, order and overflow limit.
// Depends on ciir_pkg.
module ciir_cfg
  import ciir_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sections <= SECC_W'(1);
      cfg.order    <= ORDC_W'(2);
      cfg.limit    <= '1;
    end else if (wr) begin
      case (reg_sel)
        REG_SECTIONS: cfg.sections <= pwdata[SECC_W-1:0];
        REG_ORDER:    cfg.order    <= pwdata[ORDC_W-1:0];
        REG_LIMIT:    cfg.limit    <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_SECTIONS: prdata = DATA_W'(cfg.sections);
      REG_ORDER:    prdata = DATA_W'(cfg.order);
      REG_LIMIT:    prdata = DATA_W'(cfg.limit);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: rtl/ciir_cell.sv
// One direct-form-I section: coefficients, histories and a serial MAC.
// Takes a sample from its left neighbor, hands the clamped output right.
// Depends on ciir_pkg.
module ciir_cell
  import ciir_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] x_in,
  input  logic [ORD_W-1:0]           ord,
  input  logic [LIMIT_W-1:0]         limit,
  input  coef_wr_t                   cwr,
  output cell_st_t                   st
);

  cell_state_t state, state_next;
  logic load, step, finish;

  logic [TAP_W-1:0] j, tap, pole_k, yh_off, coef_idx, last_tap;
  logic             zero_tap;

  logic signed [COEF_W-1:0]   coef [TAPS];
  logic signed [SAMPLE_W-1:0] xh [ORDER+1];
  logic signed [SAMPLE_W-1:0] yh [ORDER];

  logic signed [COEF_W-1:0]   c_sel;
  logic signed [SAMPLE_W-1:0] d_sel;
  logic signed [PROD_W-1:0]   p;
  logic                       neg;
  logic signed [ACC_W-1:0]    acc, term, acc_sum;
  logic signed [YR_W-1:0]     yr, lim;
  logic signed [SAMPLE_W-1:0] y_next;
  logic                       ovf_next;

  logic                       done_q, ovf_q;
  logic signed [SAMPLE_W-1:0] y_q;

  assign st.done = done_q;
  assign st.ovf  = ovf_q;
  assign st.y    = y_q;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= C_IDLE;
    else     state <= state_next;
  end

  assign last_tap = TAP_W'({ord, 1'b0});

  always_comb begin
    state_next = state;
    load       = 1'b0;
    step       = 1'b0;
    finish     = 1'b0;
    case (state)
      C_IDLE: begin
        if (start) begin
          load       = 1'b1;
          state_next = (ord == '0) ? C_ROUND : C_MAC;
        end
      end
      C_MAC: begin
        step = 1'b1;
        if (j == last_tap) state_next = C_ROUND;
      end
      C_ROUND: begin
        finish     = 1'b1;
        state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  // tap select: zeros 0..ord first, then poles 1..ord
  assign tap      = (state == C_IDLE) ? '0 : j;
  assign zero_tap = (tap <= TAP_W'(ord));
  assign pole_k   = tap - TAP_W'(ord);
  assign yh_off   = pole_k - TAP_W'(1);
  assign coef_idx = zero_tap ? tap : pole_k + TAP_W'(ORDER);
  assign c_sel    = coef[coef_idx];

  always_comb begin
    if (tap == '0)    d_sel = x_in;
    else if (zero_tap) d_sel = xh[tap[XH_W-1:0]];
    else               d_sel = yh[yh_off[YH_W-1:0]];
  end

  // accumulate the registered product
  assign term    = neg ? -ACC_W'(p) : ACC_W'(p);
  assign acc_sum = acc + term;

  // round (bias preloaded), then clamp to the limit
  assign yr  = acc_sum[ACC_W-1:FRAC_SHIFT];
  assign lim = $signed({{(YR_W-LIMIT_W){1'b0}}, limit});

  always_comb begin
    ovf_next = 1'b1;
    if (yr > lim)       y_next = SAMPLE_W'(lim);
    else if (yr < -lim) y_next = SAMPLE_W'(-lim);
    else begin
      y_next   = SAMPLE_W'(yr);
      ovf_next = 1'b0;
    end
  end

  // tap counter and MAC datapath
  always_ff @(posedge clk) begin
    if (cwr.we) coef[cwr.tap] <= cwr.value;
    if (load) j <= TAP_W'(1);
    else if (step) j <= j + TAP_W'(1);
    if (load || step) begin
      p   <= c_sel * d_sel;
      neg <= !zero_tap;
    end
    if (load) acc <= ACC_W'(ROUND_BIAS);
    else if (step) acc <= acc_sum;
  end

  // histories: shift only the entries in use
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= ORDER; k++) xh[k] <= '0;
      for (int k = 0; k < ORDER; k++)  yh[k] <= '0;
    end else begin
      if (load) xh[0] <= x_in;
      if (finish && ord != '0) begin
        for (int k = 1; k <= ORDER; k++) begin
          if (ORD_W'(k) <= ord) xh[k] <= xh[k-1];
        end
        for (int k = 1; k < ORDER; k++) begin
          if (ORD_W'(k) < ord) yh[k] <= yh[k-1];
        end
        yh[0] <= y_next;
      end
    end
  end

  // hand-off to the next section
  always_ff @(posedge clk) begin
    if (rst) done_q <= 1'b0;
    else     done_q <= finish;
    if (finish) begin
      y_q   <= y_next;
      ovf_q <= ovf_next;
    end
  end

endmodule

// File: dv/tb_cascaded_iir_filter_top.sv
// Self-checking testbench for cascaded_iir_filter_top: loads the coefficient table,
// runs directed and random samples over many register settings, checks each output.
// Depends on ciir_pkg and the RTL of cascaded_iir_filter_top.
`timescale 1ns / 100ps

module tb_cascaded_iir_filter_top;
  import ciir_pkg::*;

  localparam int  MAX_WAIT      = 18;
  localparam int  SETTLE_CYCLES = 100;   // above the worst-case input-to-result latency
  localparam int  STALL_LIMIT   = 2000;  // cycles without any transfer
  localparam int  MAX_REPORTS   = 10;
  localparam int  RANDOM_PHASES = 13;
  localparam int  PHASE_ITEMS   = 100;
  localparam int  PAUSE_PHASE   = 6;
  localparam int  COEF_SLOTS    = SECTIONS * TAPS;
  localparam int  LIMIT_MAX     = (1 << LIMIT_W) - 1;
  localparam int  IDX_MAX       = (1 << IDX_W) - 1;
  localparam longint HALF_LSB   = longint'(1) << (FRAC_SHIFT - 1);

  typedef struct {
    logic signed [SAMPLE_W-1:0] y;
    logic                       ovf;
    logic [SEC_FIELD_W-1:0]     sec;
  } filter_out_t;

  // Bit-exact copy of the section chain plus the queue of outputs still owed
  class cascade_checker;
    logic signed [COEF_W-1:0] coef [COEF_SLOTS];
    longint                   x_hist [SECTIONS][ORDER+1];
    longint                   y_hist [SECTIONS][ORDER];
    bit                       flag_on;
    logic [SEC_FIELD_W-1:0]   flag_sec;
    logic [SECC_W-1:0]        cfg_sections;
    logic [ORDC_W-1:0]        cfg_order;
    longint                   cfg_limit;
    filter_out_t              filtered_q[$];
    int                       bad_count;
    int                       matched;

    function new();
      foreach (coef[i]) coef[i] = '0;
      foreach (x_hist[i, j]) x_hist[i][j] = 0;
      foreach (y_hist[i, j]) y_hist[i][j] = 0;
      flag_on      = 1'b0;
      flag_sec     = '0;
      cfg_sections = 4'd1;
      cfg_order    = 3'd2;
      cfg_limit    = LIMIT_MAX;
      bad_count    = 0;
      matched      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_SECTIONS: cfg_sections = v[SECC_W-1:0];
        REG_ORDER:    cfg_order = v[ORDC_W-1:0];
        REG_LIMIT:    cfg_limit = longint'(v[LIMIT_W-1:0]);
        default: ;
      endcase
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction

    function void fail_note(string what);
      bad_count++;
      if (bad_count <= MAX_REPORTS) $display("MISMATCH: %s", what);
    endfunction

    // One accepted input transfer: table write or a sample through the chain
    function void take_input(logic f, logic signed [SAMPLE_IN_W-1:0] smp, logic lst,
                             logic [IDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
      int          ns;
      int          no;
      int          s;
      int          k;
      int          base;
      longint      x;
      longint      acc;
      longint      y;
      filter_out_t r;
      ns = (cfg_sections > SECTIONS) ? SECTIONS : int'(cfg_sections);
      no = (cfg_order > ORDER) ? ORDER : int'(cfg_order);
      if (f == FUNC_COEF) begin
        if (idx < COEF_SLOTS) coef[int'(idx)] = val;
        return;
      end
      x = longint'(smp);
      for (s = 0; s < ns; s++) begin
        base = s * TAPS;
        x_hist[s][0] = x;
        acc = longint'(coef[base]) * x;
        for (k = 1; k <= no; k++) begin
          acc += longint'(coef[base + k]) * x_hist[s][k];
          acc -= longint'(coef[base + ORDER + k]) * y_hist[s][k-1];
        end
        y = (acc + HALF_LSB) >>> FRAC_SHIFT;
        // clamp to the limit; first offending section is latched
        if (y > cfg_limit || y < -cfg_limit) begin
          y = (y > 0) ? cfg_limit : -cfg_limit;
          if (!flag_on) begin
            flag_on  = 1'b1;
            flag_sec = SEC_FIELD_W'(s);
          end
        end
        for (k = no; k >= 2; k--) begin
          x_hist[s][k]   = x_hist[s][k-1];
          y_hist[s][k-1] = y_hist[s][k-2];
        end
        if (no >= 1) begin
          x_hist[s][1] = x_hist[s][0];
          y_hist[s][0] = y;
        end
        x = y;
      end
      r.y   = x[SAMPLE_W-1:0];
      r.ovf = flag_on;
      r.sec = flag_on ? flag_sec : '0;
      filtered_q.push_back(r);
      // end of block clears the flag after its report
      if (lst) begin
        flag_on  = 1'b0;
        flag_sec = '0;
      end
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] y, logic ovf,
                               logic [SEC_FIELD_W-1:0] sec);
      filter_out_t exp_r;
      if (filtered_q.size() == 0) begin
        fail_note($sformatf("output with none pending: y=%0d ovf=%0b sec=%0d", y, ovf, sec));
        return;
      end
      exp_r = filtered_q.pop_front();
      if (y !== exp_r.y)
        fail_note($sformatf("result_sample expected %0d got %0d", exp_r.y, y));
      else if (ovf !== exp_r.ovf)
        fail_note($sformatf("overflow expected %0b got %0b (y=%0d)", exp_r.ovf, ovf, y));
      else if (sec !== exp_r.sec)
        fail_note($sformatf("overflow_section expected %0d got %0d (y=%0d)", exp_r.sec, sec, y));
      else
        matched++;
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ADDR_W-1:0]             paddr;
  logic [DATA_W-1:0]             pwdata;
  logic [DATA_W-1:0]             prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_stall;
  logic                          func;
  logic signed [SAMPLE_IN_W-1:0] sample_in;
  logic                          last_of_block;
  logic [IDX_W-1:0]              coef_index;
  logic signed [COEF_W-1:0]      coef_value;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_W-1:0]    result_sample;
  logic                          overflow;
  logic [SEC_FIELD_W-1:0]        overflow_section;

  cascade_checker chk = new();
  bit             steady;
  int             quiet_cycles;
  int             samples_seen;
  int             coef_writes;
  int             settings;
  int             flagged_outputs;

  cascaded_iir_filter_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .func             (func),
    .sample_in        (sample_in),
    .last_of_block    (last_of_block),
    .coef_index       (coef_index),
    .coef_value       (coef_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_sample    (result_sample),
    .overflow         (overflow),
    .overflow_section (overflow_section)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle cycles before the next transfer on either side
  function automatic int draw_wait();
    if (steady) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Coefficients that keep each section stable: poles sum below 0.4
  function automatic int moderate_coef(int slot);
    int tap;
    tap = slot % TAPS;
    if (tap == 0) return int'($urandom_range(2048, 12288));
    if (tap <= ORDER) return int'($urandom_range(0, 6144)) - 3072;
    return int'($urandom_range(0, 3072)) - 1536;
  endfunction

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        chk.take_input(func, sample_in, last_of_block, coef_index, coef_value);
        if (func == FUNC_FILTER) samples_seen++;
        else if (coef_index < COEF_SLOTS) coef_writes++;
      end
      if (out_valid && !out_stall) begin
        chk.check_output(result_sample, overflow, overflow_section);
        if (overflow) flagged_outputs++;
      end
    end
  end

  // Watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d outputs pending",
               quiet_cycles, chk.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: random stall before each transfer
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = draw_wait();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic send_item(input logic f, input logic signed [SAMPLE_IN_W-1:0] smp,
                           input logic lst, input logic [IDX_W-1:0] idx,
                           input logic signed [COEF_W-1:0] val);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= f;
    sample_in     <= smp;
    last_of_block <= lst;
    coef_index    <= idx;
    coef_value    <= val;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.pending() != 0);
  endtask

  // Idle point for register writes: all outputs in, table writes retired
  task automatic settle();
    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    chk.set_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int nsec, input int nord, input int lim);
    reg_write(REG_SECTIONS, DATA_W'(nsec));
    reg_write(REG_ORDER, DATA_W'(nord));
    reg_write(REG_LIMIT, DATA_W'(lim));
    settings++;
  endtask

  task automatic random_item(inout int n);
    int               pick;
    logic [IDX_W-1:0] slot;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      send_item(FUNC_FILTER, SAMPLE_IN_W'($urandom), $urandom_range(0, 7) == 0,
                IDX_W'($urandom), COEF_W'($urandom));
      n++;
    end else if (pick < 95) begin
      slot = IDX_W'($urandom_range(0, COEF_SLOTS - 1));
      send_item(FUNC_COEF, SAMPLE_IN_W'($urandom), 1'($urandom), slot,
                ($urandom_range(0, 7) == 0) ? COEF_W'($urandom)
                                            : COEF_W'(moderate_coef(int'(slot))));
      n++;
    end else begin
      // slot past the table: must be ignored
      send_item(FUNC_COEF, SAMPLE_IN_W'($urandom), 1'($urandom),
                IDX_W'($urandom_range(COEF_SLOTS, IDX_MAX)), COEF_W'($urandom));
    end
  endtask

  task automatic random_setting();
    int nsec;
    int nord;
    int lim;
    nsec = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, SECTIONS);
    nord = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, ORDER);
    case ($urandom_range(0, 3))
      0, 1:    lim = LIMIT_MAX;
      2:       lim = $urandom_range(2000, 40000);
      default: lim = $urandom_range(0, LIMIT_MAX);
    endcase
    apply_setting(nsec, nord, lim);
  endtask

  initial begin
    int n;
    int phase;
    bit paused;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid      <= 1'b0;
    func          <= FUNC_FILTER;
    sample_in     <= '0;
    last_of_block <= 1'b0;
    coef_index    <= '0;
    coef_value    <= '0;
    steady        = 1'b0;
    paused        = 1'b0;
    quiet_cycles  = 0;
    samples_seen  = 0;
    coef_writes   = 0;
    settings      = 0;
    flagged_outputs = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Whole table loaded before any sample runs
    for (n = 0; n < COEF_SLOTS; n++)
      send_item(FUNC_COEF, SAMPLE_IN_W'($urandom), 1'b0, IDX_W'(n),
                COEF_W'(moderate_coef(n)));

    // Sample extremes through the reset setting (1 section, order 2)
    send_item(FUNC_FILTER, 16'sh7fff, 1'b0, '0, '0);
    send_item(FUNC_FILTER, 16'sh8000, 1'b0, '0, '0);
    send_item(FUNC_FILTER, 16'sh0000, 1'b0, '0, '0);
    send_item(FUNC_FILTER, -16'sd1, 1'b1, '0, '0);
    // out-of-range slots are dropped
    send_item(FUNC_COEF, '0, 1'b0, IDX_W'(COEF_SLOTS), 18'sh1ffff);
    send_item(FUNC_COEF, '0, 1'b0, IDX_W'(IDX_MAX), 18'sh20000);
    // coefficient extremes on b0 of section 0
    send_item(FUNC_COEF, '0, 1'b0, '0, 18'sh1ffff);
    send_item(FUNC_FILTER, 16'sh7fff, 1'b0, '0, '0);
    send_item(FUNC_COEF, '0, 1'b0, '0, 18'sh20000);
    send_item(FUNC_FILTER, 16'sh8000, 1'b1, '0, '0);
    send_item(FUNC_COEF, '0, 1'b0, '0, COEF_W'(moderate_coef(0)));

    // Zero sections: straight pass-through
    settle();
    apply_setting(0, 0, LIMIT_MAX);
    send_item(FUNC_FILTER, 16'sh7fff, 1'b0, '0, '0);
    send_item(FUNC_FILTER, 16'sh8000, 1'b1, '0, '0);
    // Order zero: b0 only, histories not shifted
    settle();
    apply_setting(3, 0, LIMIT_MAX);
    send_item(FUNC_FILTER, 16'sd12345, 1'b0, '0, '0);
    send_item(FUNC_FILTER, -16'sd20000, 1'b1, '0, '0);
    // Saturating counts with a tight limit: flag held to end of block, then cleared
    settle();
    apply_setting(15, 7, 1000);
    send_item(FUNC_FILTER, 16'sh7fff, 1'b0, '0, '0);
    send_item(FUNC_FILTER, 16'sh8000, 1'b1, '0, '0);
    send_item(FUNC_FILTER, 16'sd5, 1'b0, '0, '0);
    // Zero limit at full size
    settle();
    apply_setting(SECTIONS, ORDER, 0);
    send_item(FUNC_FILTER, 16'sd20000, 1'b0, '0, '0);
    send_item(FUNC_FILTER, 16'sd0, 1'b1, '0, '0);

    // Random phases, each under its own register setting
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      if (phase == 0) apply_setting(SECTIONS, ORDER, LIMIT_MAX);
      else random_setting();
      steady = (phase == 1) || ($urandom_range(0, 4) == 0);
      n = 0;
      while (n < PHASE_ITEMS) begin
        random_item(n);
        if (phase == PAUSE_PHASE && n == PHASE_ITEMS / 2 && !paused) begin
          drain_outputs();
          paused = 1'b1;
        end
      end
    end
    steady = 1'b0;
    settle();

    $display("Covered %0d samples and %0d table writes over %0d register settings;",
             samples_seen, coef_writes, settings);
    $display("%0d outputs matched, %0d of them with the overflow flag set.",
             chk.matched, flagged_outputs);
    if (chk.bad_count == 0 && chk.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
